>>> design/tidst_pkg.sv
// Package for the thread id slot table: sizes, operation and status codes,
// and the request and response structs. Depends on nothing.

package tidst_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 31;
    localparam int VALUE_W = 64;
    localparam int SLOT_W  = 4;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUPLICATE = 2'd3
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] value_out;
        logic [SLOT_W-1:0]  slot;
    } t_rsp;

endpackage

>>> design/tidst_if.sv
// Valid/ready channel interfaces for the thread id slot table: the request
// channel and the response channel. Depends on tidst_pkg for field widths.

interface tidst_req_if import tidst_pkg::*;;
    logic               valid;
    logic               ready;
    logic [0:0]         operation;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface tidst_rsp_if import tidst_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [VALUE_W-1:0] value_out;
    logic [SLOT_W-1:0]  slot;

    modport source (output valid, output status, output value_out, output slot, input ready);
    modport sink   (input valid, input status, input value_out, input slot, output ready);
endinterface

>>> design/thread_id_slot_table_top.sv
// Top level of the thread id slot table: request register, table, response
// register. Depends on tidst_pkg, tidst_if and tidst_table.

// Thread id slot table.
// A request transaction on i_req carries an operation, a 31-bit thread id key
// and a 64-bit value. An insert stores key and value in the lowest-numbered
// free slot; a remove looks up the key, returns its value and frees the slot.
// Every request gives exactly one response transaction on o_rsp with a status
// (ok, key not found, table full, duplicate key), the removed value and the
// slot number; value and slot read zero unless the status is ok.
// Path: a request accepted on i_req is captured in the request register and
// then moves through the table into the response register, which drives
// o_rsp; a stall on o_rsp can hold it in the request register.
// Throughput: one transaction per cycle while o_rsp does not stall. The
// match across all slots and the first-free search sit between the two
// registers, and the table updates in the same cycle, so back-to-back
// requests always see the previous result.
// Reset (synchronous, active low) empties the table and both registers.
// When o_rsp stalls, the response register holds its transaction, one more
// request waits in the request register, and then i_req.ready drops.

module thread_id_slot_table_top import tidst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tidst_req_if.sink          i_req,
    tidst_rsp_if.source        o_rsp
);

    logic               r_in_valid;
    logic               r_out_valid;
    t_req               r_in;
    t_rsp               r_out;
    t_rsp               table_rsp;
    logic               advance;

    // A request moves into the table stage when the response register is
    // free or is being emptied in this cycle.
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.operation <= t_op'(i_req.operation);
            r_in.key       <= i_req.key;
            r_in.value     <= i_req.value;
        end
    end

    tidst_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_req   (r_in),
        .o_rsp   (table_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= table_rsp;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.value_out = r_out.value_out;
    assign o_rsp.slot      = r_out.slot;

endmodule

>>> design/tidst_table.sv
// Slot storage with parallel key match, first-free search and update.
// Depends on tidst_pkg.

module tidst_table import tidst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_req i_req,
    output t_rsp o_rsp
);

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] n_valid;
    logic [KEY_W-1:0]   r_key   [ENTRIES];
    logic [VALUE_W-1:0] r_value [ENTRIES];

    logic [ENTRIES-1:0] hit_vec;
    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic               free_any;
    logic [IDX_W-1:0]   free_idx;
    logic               do_write;
    logic               do_free;

    // Every valid slot compares its key against the request at once.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_key[i] == i_req.key);
        end
    end

    assign hit_any  = |hit_vec;
    assign free_any = ~&r_valid;

    // Lowest-numbered matching slot and lowest-numbered free slot.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_rsp    = '{status: ST_OK, value_out: '0, slot: '0};
        do_write = 1'b0;
        do_free  = 1'b0;
        unique case (i_req.operation)
            OP_INSERT: begin
                if (hit_any) begin
                    o_rsp.status = ST_DUPLICATE;
                end else if (!free_any) begin
                    o_rsp.status = ST_FULL;
                end else begin
                    o_rsp.slot = SLOT_W'(free_idx);
                    do_write   = i_en;
                end
            end
            OP_REMOVE: begin
                if (!hit_any) begin
                    o_rsp.status = ST_NOT_FOUND;
                end else begin
                    o_rsp.value_out = r_value[hit_idx];
                    o_rsp.slot      = SLOT_W'(hit_idx);
                    do_free         = i_en;
                end
            end
            default: begin
                o_rsp.status = ST_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (do_write) begin
            n_valid[free_idx] = 1'b1;
        end
        if (do_free) begin
            n_valid[hit_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_key[free_idx]   <= i_req.key;
            r_value[free_idx] <= i_req.value;
        end
    end

    // Duplicate inserts are rejected, so a key lives in at most one slot.
    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("key held by more than one valid slot");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("successful insert did not occupy exactly one slot");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_free |=> ($countones(r_valid) + 1 == $past($countones(r_valid))))
        else $error("successful remove did not free exactly one slot");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_valid))
        else $error("slot occupancy changed without a request in progress");

endmodule
